// File: hdl/hbu_pkg.sv
package hbu_pkg;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2,
    OP_NOP  = 2'd3
  } opcode_e;

  // Half-bit counts within one frame.
  parameter logic [4:0] TX_DATA_FIRST = 5'd2;
  parameter logic [4:0] TX_DATA_LAST  = 5'd16;
  parameter logic [4:0] TX_STOP_CNT   = 5'd18;
  parameter logic [4:0] TX_FRAME_END  = 5'd20;
  parameter logic [4:0] RX_SAMPLE_FIRST = 5'd3;
  parameter logic [4:0] RX_FRAME_END    = 5'd18;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_status_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic overflow;
    logic pop_valid;
  } rx_status_t;

endpackage

// File: hdl/half_bit_uart_transceiver.sv
// Channel  Handshake                Payload
// in       in_valid_i / in_ready_o  opcode_i, tx_data_i, rx_level_i
// out      out_valid_o / out_ready_i tx_line_o, push_ok_o, pop_valid_o, pop_data_o,
//                                    rx_done_o, rx_overflow_o, tx_busy_o, rx_busy_o
//
// One transaction is taken per cycle while the result is not stalled; its result
// is shown in the next cycle. The queue memories have registered reads; their read
// registers carry the popped byte and the transmit shift byte.
// Reset clears all counters and pointers; the queue memories are not cleared.
// A stalled result holds the input off; a new transaction is taken in the
// cycle its predecessor's result is taken.
module half_bit_uart_transceiver #(
  parameter int unsigned TX_DEPTH = 16,
  parameter int unsigned RX_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] tx_data_i,
  input  logic       rx_level_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       tx_line_o,
  output logic       push_ok_o,
  output logic       pop_valid_o,
  output logic [7:0] pop_data_o,
  output logic       rx_done_o,
  output logic       rx_overflow_o,
  output logic       tx_busy_o,
  output logic       rx_busy_o
);

  logic                accept, tick, push, pop, push_ok;
  logic                out_valid_q, out_valid_d;
  logic                res_push_ok_q;
  logic                res_done_q, res_ovf_q, res_pop_q;
  logic [7:0]          rx_data;
  hbu_pkg::tx_status_t tx_status;
  hbu_pkg::rx_status_t rx_status;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    tick = 1'b0;
    push = 1'b0;
    pop  = 1'b0;
    unique case (hbu_pkg::opcode_e'(opcode_i))
      hbu_pkg::OP_TICK: tick = accept;
      hbu_pkg::OP_PUSH: push = accept;
      hbu_pkg::OP_POP:  pop  = accept;
      hbu_pkg::OP_NOP:  ;
      default:          ;
    endcase
  end

  hbu_tx #(
    .DEPTH(TX_DEPTH)
  ) u_tx (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick),
    .push_i   (push),
    .data_i   (tx_data_i),
    .push_ok_o(push_ok),
    .status_o (tx_status)
  );

  hbu_rx #(
    .DEPTH(RX_DEPTH)
  ) u_rx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (tick),
    .pop_i     (pop),
    .level_i   (rx_level_i),
    .pop_data_o(rx_data),
    .status_o  (rx_status)
  );

  assign out_valid_d = accept || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_push_ok_q <= push_ok;
      res_done_q    <= rx_status.done;
      res_ovf_q     <= rx_status.overflow;
      res_pop_q     <= rx_status.pop_valid;
    end
  end

  // Engine state only moves on an accepted transaction, so it stands for the
  // state after the step as long as the result is pending.
  assign out_valid_o   = out_valid_q;
  assign tx_line_o     = tx_status.line;
  assign tx_busy_o     = tx_status.busy;
  assign rx_busy_o     = rx_status.busy;
  assign push_ok_o     = res_push_ok_q;
  assign pop_valid_o   = res_pop_q;
  assign pop_data_o    = res_pop_q ? rx_data : 8'd0;
  assign rx_done_o     = res_done_q;
  assign rx_overflow_o = res_ovf_q;

  a_ovf_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_ovf_q) |-> res_done_q)
    else $error("overflow reported without a completed byte");

  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($countones({res_push_ok_q, res_pop_q, res_done_q}) <= 1))
    else $error("more than one kind of event in one result");

endmodule

// File: hdl/hbu_ram.sv
module hbu_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read of the entry written in the same cycle returns the new data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/hbu_tx.sv
module hbu_tx #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   tick_i,
  input  logic                   push_i,
  input  logic [7:0]             data_i,
  output logic                   push_ok_o,
  output hbu_pkg::tx_status_t    status_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [PTR_W-1:0] rp_q, rp_d, rp_inc, waddr;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [4:0]       half_q, half_d, half_inc;
  logic [2:0]       bit_q, bit_d;
  logic             active_q, active_d;
  logic             level_q, level_d;
  logic [PTR_W:0]   wsum;
  logic             load, avail, take;
  logic [7:0]       shift;

  assign push_ok_o = push_i && (cnt_q != CNT_W'(DEPTH));
  assign avail     = push_ok_o || (cnt_q != '0);
  assign take      = load && avail;
  assign rp_inc    = (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
  assign wsum      = (PTR_W+1)'(rp_q) + (PTR_W+1)'(cnt_q);
  assign waddr     = (wsum >= (PTR_W+1)'(DEPTH)) ? PTR_W'(wsum - (PTR_W+1)'(DEPTH))
                                                 : PTR_W'(wsum);
  assign half_inc  = half_q + 5'd1;

  always_comb begin
    rp_d     = rp_q;
    half_d   = half_q;
    bit_d    = bit_q;
    active_d = active_q;
    level_d  = level_q;
    load     = 1'b0;
    if (tick_i && active_q) begin
      half_d = half_inc;
      if (half_inc >= hbu_pkg::TX_STOP_CNT) begin
        level_d = 1'b1;
      end
      if (half_inc >= hbu_pkg::TX_FRAME_END) begin
        load = 1'b1;
      end else if (!half_inc[0] && (half_inc >= hbu_pkg::TX_DATA_FIRST) &&
                   (half_inc <= hbu_pkg::TX_DATA_LAST)) begin
        level_d = shift[bit_q];
        bit_d   = bit_q + 3'd1;
      end
    end else if (push_ok_o && !active_q) begin
      load = 1'b1;
    end
    if (load) begin
      half_d = '0;
      bit_d  = '0;
      if (avail) begin
        rp_d     = rp_inc;
        level_d  = 1'b0;
        active_d = 1'b1;
      end else begin
        active_d = 1'b0;
      end
    end
  end

  always_comb begin
    case ({push_ok_o, take})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q     <= '0;
      cnt_q    <= '0;
      half_q   <= '0;
      bit_q    <= '0;
      active_q <= 1'b0;
      level_q  <= 1'b1;
    end else begin
      rp_q     <= rp_d;
      cnt_q    <= cnt_d;
      half_q   <= half_d;
      bit_q    <= bit_d;
      active_q <= active_d;
      level_q  <= level_d;
    end
  end

  // The read register of the queue memory doubles as the shift register:
  // a byte loaded by a push into an idle transmitter is forwarded.
  hbu_ram #(
    .DEPTH(DEPTH),
    .WIDTH(8)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (push_ok_o),
    .waddr_i(waddr),
    .wdata_i(data_i),
    .re_i   (take),
    .raddr_i(rp_q),
    .rdata_o(shift)
  );

  assign status_o.line = level_q;
  assign status_o.busy = active_q;

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (cnt_q == '0))
    else $error("transmitter idle with bytes queued");

  a_push_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_ok_o && !active_q) |=> active_q)
    else $error("push into idle transmitter did not start a frame");

endmodule

// File: hdl/hbu_rx.sv
module hbu_rx #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   tick_i,
  input  logic                   pop_i,
  input  logic                   level_i,
  output logic [7:0]             pop_data_o,
  output hbu_pkg::rx_status_t    status_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [PTR_W-1:0] rp_q, rp_d, waddr;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [4:0]       half_q, half_d, half_inc;
  logic [2:0]       bit_q, bit_d;
  logic             active_q, active_d;
  logic [7:0]       shift_q, shift_d;
  logic [PTR_W:0]   wsum;
  logic             done, full, wr, rd;

  assign full     = (cnt_q == CNT_W'(DEPTH));
  assign half_inc = half_q + 5'd1;
  assign done     = tick_i && active_q && (half_inc >= hbu_pkg::RX_FRAME_END);
  assign wr       = done && !full;
  assign rd       = pop_i && (cnt_q != '0);
  assign wsum     = (PTR_W+1)'(rp_q) + (PTR_W+1)'(cnt_q);
  assign waddr    = (wsum >= (PTR_W+1)'(DEPTH)) ? PTR_W'(wsum - (PTR_W+1)'(DEPTH))
                                                : PTR_W'(wsum);

  always_comb begin
    half_d   = half_q;
    bit_d    = bit_q;
    active_d = active_q;
    shift_d  = shift_q;
    if (tick_i) begin
      if (!active_q) begin
        // A low line on an idle tick is the start bit; counting begins next tick.
        if (!level_i) begin
          active_d = 1'b1;
          half_d   = '0;
          bit_d    = '0;
          shift_d  = '0;
        end
      end else if (done) begin
        active_d = 1'b0;
        half_d   = '0;
        bit_d    = '0;
        shift_d  = '0;
      end else begin
        half_d = half_inc;
        if ((half_inc >= hbu_pkg::RX_SAMPLE_FIRST) && half_inc[0]) begin
          if (level_i) begin
            shift_d[bit_q] = 1'b1;
          end
          bit_d = bit_q + 3'd1;
        end
      end
    end
  end

  always_comb begin
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (wr) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (rd) begin
      cnt_d = cnt_q - CNT_W'(1);
      rp_d  = (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q     <= '0;
      cnt_q    <= '0;
      half_q   <= '0;
      bit_q    <= '0;
      active_q <= 1'b0;
      shift_q  <= '0;
    end else begin
      rp_q     <= rp_d;
      cnt_q    <= cnt_d;
      half_q   <= half_d;
      bit_q    <= bit_d;
      active_q <= active_d;
      shift_q  <= shift_d;
    end
  end

  hbu_ram #(
    .DEPTH(DEPTH),
    .WIDTH(8)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr),
    .waddr_i(waddr),
    .wdata_i(shift_q),
    .re_i   (rd),
    .raddr_i(rp_q),
    .rdata_o(pop_data_o)
  );

  assign status_o.busy      = active_q;
  assign status_o.done      = done;
  assign status_o.overflow  = done && full;
  assign status_o.pop_valid = rd;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("receive queue count beyond depth");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !active_q)
    else $error("receiver still busy after completing a byte");

endmodule

// File: verif/tb_half_bit_uart_transceiver.sv
module tb_half_bit_uart_transceiver;

  localparam int unsigned FIFO_DEPTH   = 16;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic       tx_line;
    logic       push_ok;
    logic       pop_valid;
    logic [7:0] pop_data;
    logic       rx_done;
    logic       rx_overflow;
    logic       tx_busy;
    logic       rx_busy;
  } uart_status_t;

  typedef enum logic [1:0] {
    MIX_TRAFFIC,
    RX_FLOOD,
    TX_BURST,
    RX_DRAIN
  } traffic_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] opcode_i;
  logic [7:0] tx_data_i;
  logic       rx_level_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       tx_line_o;
  logic       push_ok_o;
  logic       pop_valid_o;
  logic [7:0] pop_data_o;
  logic       rx_done_o;
  logic       rx_overflow_o;
  logic       tx_busy_o;
  logic       rx_busy_o;

  half_bit_uart_transceiver u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .tx_data_i    (tx_data_i),
    .rx_level_i   (rx_level_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .tx_line_o    (tx_line_o),
    .push_ok_o    (push_ok_o),
    .pop_valid_o  (pop_valid_o),
    .pop_data_o   (pop_data_o),
    .rx_done_o    (rx_done_o),
    .rx_overflow_o(rx_overflow_o),
    .tx_busy_o    (tx_busy_o),
    .rx_busy_o    (rx_busy_o)
  );

  // Mirror of the transceiver state.
  logic [7:0]  tx_mem [FIFO_DEPTH];
  int unsigned tx_fill;
  int unsigned tx_rd;
  logic [7:0]  rx_mem [FIFO_DEPTH];
  int unsigned rx_fill;
  int unsigned rx_rd;
  logic [7:0]  tx_byte;
  logic [4:0]  tx_halves;
  logic [2:0]  tx_bit;
  logic        tx_on;
  logic        tx_lvl;
  logic [7:0]  rx_byte;
  logic [4:0]  rx_halves;
  logic [2:0]  rx_bit;
  logic        rx_on;

  uart_status_t predicted_status[$];
  logic         line_plan[$];
  int unsigned  error_count = 0;
  int unsigned  result_count = 0;
  int unsigned  cycle_count = 0;
  bit           no_idle = 1'b0;

  always #1 clk_i = ~clk_i;

  function automatic void clear_uart_mirror();
    tx_fill   = 0;
    tx_rd     = 0;
    rx_fill   = 0;
    rx_rd     = 0;
    tx_byte   = '0;
    tx_halves = '0;
    tx_bit    = '0;
    tx_on     = 1'b0;
    tx_lvl    = 1'b1;
    rx_byte   = '0;
    rx_halves = '0;
    rx_bit    = '0;
    rx_on     = 1'b0;
  endfunction

  // Load the next queued byte with a start bit, or let the transmitter idle.
  function automatic void tx_fetch();
    tx_halves = '0;
    tx_bit    = '0;
    if (tx_fill > 0) begin
      tx_byte = tx_mem[tx_rd];
      tx_rd   = (tx_rd + 1) % FIFO_DEPTH;
      tx_fill--;
      tx_lvl  = 1'b0;
      tx_on   = 1'b1;
    end else begin
      tx_byte = '0;
      tx_on   = 1'b0;
    end
  endfunction

  function automatic uart_status_t advance_uart(hbu_pkg::opcode_e op, logic [7:0] data,
                                                logic level);
    uart_status_t st;
    st = '0;
    case (op)
      hbu_pkg::OP_TICK: begin
        if (!rx_on) begin
          if (!level) begin
            rx_on     = 1'b1;
            rx_halves = '0;
            rx_bit    = '0;
            rx_byte   = '0;
          end
        end else begin
          rx_halves++;
          if (rx_halves >= hbu_pkg::RX_FRAME_END) begin
            st.rx_done = 1'b1;
            if (rx_fill < FIFO_DEPTH) begin
              rx_mem[(rx_rd + rx_fill) % FIFO_DEPTH] = rx_byte;
              rx_fill++;
            end else begin
              st.rx_overflow = 1'b1;
            end
            rx_on     = 1'b0;
            rx_halves = '0;
            rx_bit    = '0;
            rx_byte   = '0;
          end else if (rx_halves >= hbu_pkg::RX_SAMPLE_FIRST && rx_halves[0]) begin
            if (level) rx_byte[rx_bit] = 1'b1;
            rx_bit++;
          end
        end
        if (tx_on) begin
          tx_halves++;
          if (tx_halves >= hbu_pkg::TX_STOP_CNT) tx_lvl = 1'b1;
          if (tx_halves >= hbu_pkg::TX_FRAME_END) begin
            tx_fetch();
          end else if (tx_halves >= hbu_pkg::TX_DATA_FIRST &&
                       tx_halves <= hbu_pkg::TX_DATA_LAST && !tx_halves[0]) begin
            tx_lvl = tx_byte[tx_bit];
            tx_bit++;
          end
        end
      end
      hbu_pkg::OP_PUSH: begin
        if (tx_fill < FIFO_DEPTH) begin
          tx_mem[(tx_rd + tx_fill) % FIFO_DEPTH] = data;
          tx_fill++;
          st.push_ok = 1'b1;
          if (!tx_on) tx_fetch();
        end
      end
      hbu_pkg::OP_POP: begin
        if (rx_fill > 0) begin
          st.pop_data  = rx_mem[rx_rd];
          rx_rd        = (rx_rd + 1) % FIFO_DEPTH;
          rx_fill--;
          st.pop_valid = 1'b1;
        end
      end
      default: ;
    endcase
    st.tx_line = tx_lvl;
    st.tx_busy = tx_on;
    st.rx_busy = rx_on;
    return st;
  endfunction

  // Plans upcoming receive line levels: mostly whole frames, sometimes idle
  // or glitches. A frame with no stop bit puts the next start bit on the
  // tick that completes the previous byte.
  function automatic void plan_rx_activity(bit frames_only);
    int unsigned pick;
    int unsigned stop_len;
    logic [7:0]  value;
    pick = frames_only ? 99 : $urandom_range(0, 99);
    if (pick < 20) begin
      repeat ($urandom_range(1, 8)) line_plan.push_back(1'b1);
    end else if (pick < 25) begin
      repeat ($urandom_range(1, 4)) line_plan.push_back(1'($urandom_range(0, 1)));
    end else begin
      value    = 8'($urandom);
      stop_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      line_plan.push_back(1'b0);
      line_plan.push_back(1'b0);
      for (int i = 0; i < 8; i++) begin
        line_plan.push_back(value[i]);
        line_plan.push_back(value[i]);
      end
      repeat (stop_len) line_plan.push_back(1'b1);
    end
  endfunction

  function automatic logic next_rx_level(bit frames_only, bit loopback);
    if (loopback) return tx_lvl;
    if (line_plan.size() == 0) plan_rx_activity(frames_only);
    return line_plan.pop_front();
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    $display("ERROR result %0d: %s", result_count, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
  endtask

  // Sends one transaction; the task starts and ends on a rising edge.
  task automatic send_item(hbu_pkg::opcode_e op, logic [7:0] data, logic level);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    tx_data_i  <= data;
    rx_level_i <= level;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    predicted_status.push_back(advance_uart(op, data, level));
  endtask

  task automatic wait_for_predicted();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (predicted_status.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_idle_status();
    send_item(hbu_pkg::OP_NOP, 8'($urandom), 1'b0);
    send_item(hbu_pkg::OP_POP, 8'($urandom), 1'b1);
    send_item(hbu_pkg::OP_TICK, 8'($urandom), 1'b1);
    send_item(hbu_pkg::OP_NOP, 8'($urandom), 1'b1);
  endtask

  // The first byte goes straight into the shifter, so the next 16 fill the
  // queue and the last push is refused.
  task automatic test_tx_fifo_full();
    send_item(hbu_pkg::OP_PUSH, 8'h00, 1'b0);
    send_item(hbu_pkg::OP_PUSH, 8'hFF, 1'b1);
    repeat (FIFO_DEPTH - 1) begin
      send_item(hbu_pkg::OP_PUSH, 8'($urandom), 1'($urandom_range(0, 1)));
    end
    send_item(hbu_pkg::OP_PUSH, 8'($urandom), 1'($urandom_range(0, 1)));
    send_item(hbu_pkg::OP_POP, 8'($urandom), 1'($urandom_range(0, 1)));
    repeat (3) send_item(hbu_pkg::OP_TICK, 8'($urandom), 1'b1);
    wait_for_predicted();
  endtask

  // Back-to-back frames with no pops run the receive queue into overflow.
  task automatic test_rx_overflow();
    line_plan.delete();
    repeat (400) send_item(hbu_pkg::OP_TICK, 8'($urandom), next_rx_level(1'b1, 1'b0));
    repeat (FIFO_DEPTH + 1) begin
      send_item(hbu_pkg::OP_POP, 8'($urandom), 1'($urandom_range(0, 1)));
    end
    wait_for_predicted();
  endtask

  task automatic test_random_traffic();
    int unsigned      counted;
    int unsigned      pick;
    traffic_mode_e    mode;
    bit               loopback;
    hbu_pkg::opcode_e op;
    logic             level;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)      mode = MIX_TRAFFIC;
      else if (pick < 6) mode = RX_FLOOD;
      else if (pick < 8) mode = TX_BURST;
      else               mode = RX_DRAIN;
      loopback = (mode != RX_FLOOD) && ($urandom_range(0, 2) == 0);
      no_idle  = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(40, 150)) begin
        pick = $urandom_range(0, 99);
        case (mode)
          MIX_TRAFFIC: op = (pick < 55) ? hbu_pkg::OP_TICK :
                            (pick < 72) ? hbu_pkg::OP_PUSH :
                            (pick < 90) ? hbu_pkg::OP_POP : hbu_pkg::OP_NOP;
          RX_FLOOD:    op = (pick < 96) ? hbu_pkg::OP_TICK : hbu_pkg::OP_NOP;
          TX_BURST:    op = (pick < 60) ? hbu_pkg::OP_PUSH :
                            (pick < 90) ? hbu_pkg::OP_TICK : hbu_pkg::OP_POP;
          default:     op = (pick < 60) ? hbu_pkg::OP_POP :
                            (pick < 90) ? hbu_pkg::OP_TICK : hbu_pkg::OP_PUSH;
        endcase
        if (op == hbu_pkg::OP_TICK) level = next_rx_level(mode == RX_FLOOD, loopback);
        else                        level = 1'($urandom_range(0, 1));
        send_item(op, 8'($urandom), level);
        if (op != hbu_pkg::OP_NOP) counted++;
      end
      if ($urandom_range(0, 7) == 0) wait_for_predicted();
    end
    no_idle = 1'b0;
  endtask

  initial begin : result_checker
    uart_status_t seen;
    uart_status_t want;
    int unsigned  stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(negedge clk_i);
      while (!out_valid_o) @(negedge clk_i);
      seen.tx_line     = tx_line_o;
      seen.push_ok     = push_ok_o;
      seen.pop_valid   = pop_valid_o;
      seen.pop_data    = pop_data_o;
      seen.rx_done     = rx_done_o;
      seen.rx_overflow = rx_overflow_o;
      seen.tx_busy     = tx_busy_o;
      seen.rx_busy     = rx_busy_o;
      @(posedge clk_i);
      result_count++;
      if (predicted_status.size() == 0) begin
        report_mismatch("result arrived with no transaction outstanding");
      end else begin
        want = predicted_status.pop_front();
        check_field("tx_line", 8'(seen.tx_line), 8'(want.tx_line));
        check_field("push_ok", 8'(seen.push_ok), 8'(want.push_ok));
        check_field("pop_valid", 8'(seen.pop_valid), 8'(want.pop_valid));
        check_field("pop_data", seen.pop_data, want.pop_data);
        check_field("rx_done", 8'(seen.rx_done), 8'(want.rx_done));
        check_field("rx_overflow", 8'(seen.rx_overflow), 8'(want.rx_overflow));
        check_field("tx_busy", 8'(seen.tx_busy), 8'(want.tx_busy));
        check_field("rx_busy", 8'(seen.rx_busy), 8'(want.rx_busy));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("half_bit_uart_transceiver verification failed");
    $finish;
  end

  initial begin : stimulus
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    opcode_i   = hbu_pkg::OP_NOP;
    tx_data_i  = 8'h00;
    rx_level_i = 1'b1;
    clear_uart_mirror();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_status();
    test_tx_fifo_full();
    test_rx_overflow();
    test_random_traffic();
    wait_for_predicted();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("half_bit_uart_transceiver verification clean");
    end else begin
      $display("half_bit_uart_transceiver verification failed");
    end
    $finish;
  end

endmodule
